/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

/* rtl/core/fvs_pkg.sv */
// ----------------------------------------------------------------------------
// fvs_pkg
// Shared types and constants of the four-voice square-wave synthesiser.
// ----------------------------------------------------------------------------
`default_nettype none

package fvs_pkg;

    // filter fixed point
    localparam int FILTER_FRAC_BITS = 24;

    // field and register widths
    localparam int PSS_W      = 40;
    localparam int TPW_W      = 12;
    localparam int COEFF_W    = 25;
    localparam int SIL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int WORD_W     = 18;
    localparam int SAMPLE_W   = 16;
    localparam int NUM_VOICES = 4;
    localparam int VIDX_W     = 2;
    localparam int PHASE_W    = 32;
    localparam int STEP_W     = 31;
    localparam int VOL_W      = 13;
    localparam int VCODE_W    = 3;
    localparam int Z_W        = 41;
    localparam int RAW_W      = 18;

    // voice step divider: d = 4*w + 2, compared against d * 2^30
    localparam int WVAL_W     = 15;
    localparam int D_W        = WVAL_W + 2;
    localparam int DIV_SHIFT  = 30;
    localparam int DSR_W      = D_W + DIV_SHIFT;
    localparam int DCNT_W     = $clog2(STEP_W);

    // filter datapath widths
    localparam int TGT_W  = RAW_W + FILTER_FRAC_BITS;
    localparam int DIFF_W = ((TGT_W > Z_W) ? TGT_W : Z_W) + 1;
    localparam int HI_W   = DIFF_W - FILTER_FRAC_BITS;
    localparam int PLO_W  = FILTER_FRAC_BITS + COEFF_W;
    localparam int PROD_W = HI_W + COEFF_W + 1;
    localparam int ZSUM_W = ((PROD_W > Z_W) ? PROD_W : Z_W) + 1;
    localparam int Q_W    = Z_W - FILTER_FRAC_BITS;
    localparam int QX_W   = ((Q_W > SAMPLE_W) ? Q_W : SAMPLE_W) + 1;
    localparam int SAT_LIMIT = 32767;

    // front/back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [PSS_W-1:0]          PSS_RESET   = 40'd377100076357;
    localparam logic [TPW_W-1:0]          TPW_RESET   = 12'd367;
    localparam logic [COEFF_W-1:0]        COEFF_RESET = 25'd727862;
    localparam logic signed [SIL_W-1:0]   SIL_RESET   = '0;

    // volume code to amplitude
    localparam logic [VOL_W-1:0] VOL_TABLE [2**VCODE_W] = '{
        13'd1000, 13'd2000, 13'd3000, 13'd4000,
        13'd5000, 13'd6000, 13'd7000, 13'd8000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_TICKS      = 2'd1,
        REG_COEFF      = 2'd2,
        REG_SILENCE    = 2'd3
    } cfg_reg_t;

    // what the front found in an item
    typedef enum logic [1:0] {
        WK_NONE  = 2'd0,
        WK_PLAIN = 2'd1,
        WK_MODE  = 2'd2,
        WK_VOICE = 2'd3
    } word_kind_t;

    typedef struct packed {
        word_kind_t          kind;
        logic [WORD_W-1:0]   ctrl_word;
    } item_t;

    typedef struct packed {
        logic  avail;
        item_t item;
    } q_rd_t;

endpackage

`default_nettype wire

/* rtl/core/fvs_in_if.sv */
// ----------------------------------------------------------------------------
// fvs_in_if
// Tick channel: one item per audio tick, optionally carrying a control word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvs_in_if;
    import fvs_pkg::*;

    logic              valid;
    logic              ready;
    logic              word_valid;
    logic [WORD_W-1:0] ctrl_word;

    modport source (output valid, output word_valid, output ctrl_word, input ready);
    modport sink   (input valid, input word_valid, input ctrl_word, output ready);
endinterface

`default_nettype wire

/* rtl/core/fvs_out_if.sv */
// ----------------------------------------------------------------------------
// fvs_out_if
// Result channel: one filtered sample and its status flags per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvs_out_if;
    import fvs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       word_taken;
    logic                       starved;

    modport source (output valid, output sample, output word_taken, output starved,
                    input ready);
    modport sink   (input valid, input sample, input word_taken, input starved,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/fvs_cfg_if.sv */
// ----------------------------------------------------------------------------
// fvs_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fvs_cfg_if;
    import fvs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PSS_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/fvs_front.sv */
// ----------------------------------------------------------------------------
// fvs_front
// Accepts tick items, classifies the control word and feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fvs_front (
    input  logic          clk,
    input  logic          rst_n,
    fvs_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          q_push,
    output fvs_pkg::item_t q_item
);
    import fvs_pkg::*;

    logic       hold_vld_reg;
    logic       hold_vld_next;
    item_t      hold_item_reg;
    item_t      hold_item_next;
    logic       accept;

    assign q_push       = hold_vld_reg && !q_full;
    assign q_item       = hold_item_reg;
    assign in_ch.ready  = !hold_vld_reg || !q_full;
    assign accept       = in_ch.valid && in_ch.ready;

    // top bits 11 mark a decoded word, bit 15 picks voice over mode
    always_comb
    begin
        hold_item_next.ctrl_word = in_ch.ctrl_word;
        if (!in_ch.word_valid)
        begin
            hold_item_next.kind = WK_NONE;
        end
        else if (in_ch.ctrl_word[WORD_W-1:WORD_W-2] != 2'b11)
        begin
            hold_item_next.kind = WK_PLAIN;
        end
        else if (in_ch.ctrl_word[WORD_W-3])
        begin
            hold_item_next.kind = WK_VOICE;
        end
        else
        begin
            hold_item_next.kind = WK_MODE;
        end
    end

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        if (accept)
        begin
            hold_vld_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= hold_item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fvs_queue.sv */
// ----------------------------------------------------------------------------
// fvs_queue
// Short item queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fvs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fvs_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output fvs_pkg::q_rd_t rd
);
    import fvs_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd.avail = (cnt_reg != '0);
    assign rd.item  = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd.avail;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // occupancy never runs past the depth
    `ASSERT_ALWAYS(a_q_cnt_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    // count tracks the pointers
    `ASSERT_IMPLY(a_q_ptr_match, cnt_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

/* rtl/core/fvs_back.sv */
// ----------------------------------------------------------------------------
// fvs_back
// Executes one tick: word decode, step divide, voice sum, low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fvs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  fvs_pkg::q_rd_t q_rd,
    output logic           q_pop,
    fvs_cfg_if.sink        cfg,
    fvs_out_if.source      out_ch
);
    import fvs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DEC  = 10'b00_0000_0010,
        S_DIV  = 10'b00_0000_0100,
        S_SUM  = 10'b00_0000_1000,
        S_DIFF = 10'b00_0001_0000,
        S_ABS  = 10'b00_0010_0000,
        S_MLO  = 10'b00_0100_0000,
        S_MHI  = 10'b00_1000_0000,
        S_UPD  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [PSS_W-1:0]          pss_reg;
    logic [TPW_W-1:0]          tpw_reg;
    logic [COEFF_W-1:0]        coeff_reg;
    logic signed [SIL_W-1:0]   sil_reg;

    // architectural state
    logic [PHASE_W-1:0]        phase_reg [NUM_VOICES];
    logic [STEP_W-1:0]         step_reg  [NUM_VOICES];
    logic [VOL_W-1:0]          vol_reg   [NUM_VOICES];
    logic [VIDX_W-1:0]         cur_reg;
    logic [VIDX_W-1:0]         vcnt_reg;
    logic                      hold_reg;
    logic [TPW_W-1:0]          ticks_reg;
    logic signed [Z_W-1:0]     z_reg;

    // per-item working registers
    item_t                     item_reg;
    logic                      taken_reg;
    logic                      starved_reg;
    logic [VIDX_W-1:0]         vsel_reg;
    logic [PSS_W-1:0]          rem_reg;
    logic [DSR_W-1:0]          dsr_reg;
    logic [STEP_W-1:0]         quo_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic signed [RAW_W-1:0]   raw_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [DIFF_W-1:0]         mag_reg;
    logic                      neg_reg;
    logic [PLO_W-1:0]          plo_reg;
    logic [PROD_W-1:0]         prod_reg;

    // result register
    logic                      ovld_reg;
    logic signed [SAMPLE_W-1:0] osample_reg;
    logic                      otaken_reg;
    logic                      ostarved_reg;

    // combinational helpers
    logic [WVAL_W-1:0]         wval;
    logic [D_W-1:0]            dval;
    logic [DSR_W-1:0]          dshift;
    logic                      range_bad;
    logic                      div_ge;
    logic                      div_bit;
    logic [VIDX_W-1:0]         cur_rot;
    logic signed [RAW_W-1:0]   raw_sum;
    logic signed [RAW_W-1:0]   vterm;
    logic signed [TGT_W-1:0]   target;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [PLO_W-1:0]          plo_next;
    logic [PROD_W-1:0]         phi;
    logic [PROD_W-1:0]         prod_next;
    logic signed [ZSUM_W-1:0]  zsum;
    logic                      zfits;
    logic signed [Z_W-1:0]     zsat;
    logic signed [Z_W-1:0]     zq;
    logic signed [Q_W-1:0]     qval;
    logic signed [QX_W-1:0]    qx;
    logic signed [SAMPLE_W-1:0] qsat;
    logic                      out_load;
    logic                      div_inv;
    logic                      quo_ok;

    localparam logic signed [QX_W-1:0] Q_HI = QX_W'(SAT_LIMIT);
    localparam logic signed [QX_W-1:0] Q_LO = -Q_HI;
    localparam logic signed [Z_W-1:0]  Z_ROUND =
        {{(Z_W-FILTER_FRAC_BITS){1'b0}}, {FILTER_FRAC_BITS{1'b1}}};
    localparam logic [Z_W-1:0] Z_POS_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic [Z_W-1:0] Z_NEG_MAX = {1'b1, {(Z_W-1){1'b0}}};

    assign cfg.ready = 1'b1;

    assign q_pop    = (state_reg == S_IDLE) && q_rd.avail;
    assign out_load = (state_reg == S_OUT) && (!ovld_reg || out_ch.ready);

    assign out_ch.valid      = ovld_reg;
    assign out_ch.sample     = osample_reg;
    assign out_ch.word_taken = otaken_reg;
    assign out_ch.starved    = ostarved_reg;

    // ---- voice word: d = 4w + 2, step = floor(P / d) ----
    assign wval      = item_reg.ctrl_word[WVAL_W-1:0];
    assign dval      = {wval, 2'b10};
    assign dshift    = {dval, {DIV_SHIFT{1'b0}}};
    assign range_bad = {{(DSR_W-PSS_W){1'b0}}, pss_reg} > dshift;
    assign div_ge    = {{(DSR_W-PSS_W){1'b0}}, rem_reg} >= dsr_reg;
    assign div_bit   = div_ge;
    assign cur_rot   = hold_reg ? cur_reg
                       : ((cur_reg == '0) ? vcnt_reg : cur_reg - VIDX_W'(1));

    // ---- square-wave sum ----
    always_comb
    begin
        raw_sum = RAW_W'(sil_reg);
        vterm   = '0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            vterm = signed'(RAW_W'(vol_reg[i]));
            if (step_reg[i] != '0)
            begin
                if (phase_reg[i][PHASE_W-2])
                begin
                    raw_sum = raw_sum - vterm;
                end
                else
                begin
                    raw_sum = raw_sum + vterm;
                end
            end
        end
    end

    // ---- filter: z += a * (raw * 2^F - z) / 2^F, product toward zero ----
    assign target    = {raw_reg, {FILTER_FRAC_BITS{1'b0}}};
    assign diff_next = DIFF_W'(target) - DIFF_W'(z_reg);
    assign plo_next  = mag_reg[FILTER_FRAC_BITS-1:0] * coeff_reg;
    assign phi       = mag_reg[DIFF_W-1:FILTER_FRAC_BITS] * coeff_reg;
    assign prod_next = phi + PROD_W'(plo_reg[PLO_W-1:FILTER_FRAC_BITS]);

    always_comb
    begin
        if (neg_reg)
        begin
            zsum = ZSUM_W'(z_reg) - signed'(ZSUM_W'(prod_reg));
        end
        else
        begin
            zsum = ZSUM_W'(z_reg) + signed'(ZSUM_W'(prod_reg));
        end
    end

    assign zfits = (&zsum[ZSUM_W-1:Z_W-1]) || !(|zsum[ZSUM_W-1:Z_W-1]);
    assign zsat  = zfits ? zsum[Z_W-1:0]
                   : (zsum[ZSUM_W-1] ? Z_NEG_MAX : Z_POS_MAX);

    // sample = z / 2^F toward zero, clipped to +-32767
    assign zq   = z_reg[Z_W-1] ? (z_reg + Z_ROUND) : z_reg;
    assign qval = zq[Z_W-1:FILTER_FRAC_BITS];
    assign qx   = QX_W'(qval);

    always_comb
    begin
        if (qx > Q_HI)
        begin
            qsat = SAMPLE_W'(Q_HI);
        end
        else if (qx < Q_LO)
        begin
            qsat = SAMPLE_W'(Q_LO);
        end
        else
        begin
            qsat = qx[SAMPLE_W-1:0];
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_rd.avail)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (ticks_reg != '0)
                begin
                    state_next = S_SUM;
                end
                else if (item_reg.kind == WK_NONE)
                begin
                    state_next = S_OUT;
                end
                else if (item_reg.kind == WK_VOICE && wval >= WVAL_W'(2) && !range_bad)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:  state_next = S_DIFF;
            S_DIFF: state_next = S_ABS;
            S_ABS:  state_next = S_MLO;
            S_MLO:  state_next = S_MHI;
            S_MHI:  state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control, configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pss_reg     <= PSS_RESET;
            tpw_reg     <= TPW_RESET;
            coeff_reg   <= COEFF_RESET;
            sil_reg     <= SIL_RESET;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                phase_reg[i] <= '0;
                step_reg[i]  <= '0;
                vol_reg[i]   <= '0;
            end
            cur_reg     <= '0;
            vcnt_reg    <= '0;
            hold_reg    <= 1'b0;
            ticks_reg   <= '0;
            z_reg       <= '0;
            taken_reg   <= 1'b0;
            starved_reg <= 1'b0;
            vsel_reg    <= '0;
            dcnt_reg    <= '0;
            ovld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_PHASE_STEP: pss_reg   <= cfg.data;
                    REG_TICKS:      tpw_reg   <= cfg.data[TPW_W-1:0];
                    REG_COEFF:      coeff_reg <= cfg.data[COEFF_W-1:0];
                    REG_SILENCE:    sil_reg   <= cfg.data[SIL_W-1:0];
                    default:        pss_reg   <= pss_reg;
                endcase
            end

            if (out_load)
            begin
                ovld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovld_reg <= 1'b0;
            end

            unique case (state_reg)
                S_DEC:
                begin
                    taken_reg   <= 1'b0;
                    starved_reg <= 1'b0;
                    vsel_reg    <= cur_reg;
                    if (ticks_reg == '0)
                    begin
                        if (item_reg.kind == WK_NONE)
                        begin
                            starved_reg <= 1'b1;
                        end
                        else
                        begin
                            taken_reg <= 1'b1;
                            ticks_reg <= (tpw_reg == '0) ? TPW_W'(1) : tpw_reg;
                            if (item_reg.kind == WK_MODE)
                            begin
                                hold_reg <= item_reg.ctrl_word[14];
                                vcnt_reg <= item_reg.ctrl_word[13:12];
                                cur_reg  <= item_reg.ctrl_word[13:12];
                                for (int i = 0; i < NUM_VOICES; i++)
                                begin
                                    vol_reg[i] <= VOL_TABLE[item_reg.ctrl_word[
                                        VCODE_W*(NUM_VOICES-1-i) +: VCODE_W]];
                                end
                            end
                            else if (item_reg.kind == WK_VOICE)
                            begin
                                cur_reg <= cur_rot;
                                dcnt_reg <= DCNT_W'(STEP_W - 1);
                                // rest or unreachable pitch: voice goes quiet
                                if (wval < WVAL_W'(2) || range_bad)
                                begin
                                    step_reg[cur_reg] <= '0;
                                end
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == '0)
                    begin
                        step_reg[vsel_reg] <= {quo_reg[STEP_W-2:0], div_bit};
                    end
                end
                S_SUM:
                begin
                    for (int i = 0; i < NUM_VOICES; i++)
                    begin
                        if (step_reg[i] != '0)
                        begin
                            phase_reg[i] <= phase_reg[i] + PHASE_W'(step_reg[i]);
                        end
                    end
                    ticks_reg <= ticks_reg - TPW_W'(1);
                end
                S_UPD:
                begin
                    z_reg <= zsat;
                end
                default:
                begin
                    z_reg <= z_reg;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_rd.item;
        end
        if (state_reg == S_DEC)
        begin
            rem_reg <= pss_reg;
            dsr_reg <= dshift;
            quo_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsr_reg[PSS_W-1:0];
            end
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= {quo_reg[STEP_W-2:0], div_bit};
        end
        if (state_reg == S_SUM)
        begin
            raw_reg <= raw_sum;
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= diff_next;
        end
        if (state_reg == S_ABS)
        begin
            neg_reg <= diff_reg[DIFF_W-1];
            mag_reg <= diff_reg[DIFF_W-1] ? unsigned'(-diff_reg) : unsigned'(diff_reg);
        end
        if (state_reg == S_MLO)
        begin
            plo_reg <= plo_next;
        end
        if (state_reg == S_MHI)
        begin
            prod_reg <= prod_next;
        end
        if (out_load)
        begin
            osample_reg  <= starved_reg ? sil_reg : qsat;
            otaken_reg   <= taken_reg;
            ostarved_reg <= starved_reg;
        end
    end

    // restoring division keeps the partial remainder below twice the divisor
    assign div_inv = {1'b0, {(DSR_W-PSS_W){1'b0}}, rem_reg} < {dsr_reg, 1'b0};
    // the step never exceeds 2^30 once the out-of-range case is removed
    assign quo_ok  = !quo_reg[STEP_W-2] || (quo_reg[STEP_W-3:0] == '0);

    `ASSERT_IMPLY(a_div_rem_bound, state_reg == S_DIV, div_inv)
    `ASSERT_IMPLY(a_div_quo_bound, state_reg == S_DIV && dcnt_reg == '0, quo_ok)
    `ASSERT_IMPLY(a_out_flags, out_ch.valid, !(out_ch.starved && out_ch.word_taken))

endmodule

`default_nettype wire

/* rtl/core/four_voice_square_wave_synth_top.sv */
// ----------------------------------------------------------------------------
// four_voice_square_wave_synth_top
// Four-voice square-wave tone generator with a one-pole low-pass output.
// ----------------------------------------------------------------------------
//
// Each item on in_ch is one audio tick and yields exactly one item on out_ch,
// in order. A tick carries an optional 18-bit control word; the word is only
// consumed once the word period (ticks_per_word ticks) has run out, and a
// tick that needs a word but has none returns silence_level with starved set.
// The front stage registers and classifies each tick and drops it into a
// four-deep queue, so in_ch keeps accepting, until the queue and the front
// register fill, while the back end works or while a finished sample waits
// on out_ch. The back end handles one tick at a time: a normal tick goes
// from leaving the queue to the result register through pop, decode, sum,
// difference, magnitude, two partial products of the filter multiply, state
// update and output load; a starved tick skips straight from decode to
// output load. A consumed voice word in range adds a pass through the
// pitch-step divider, which resolves one quotient bit per cycle, and out_ch
// can stall output load while the result register is held full. The
// configuration port is always ready and takes writes at any time, but
// registers should only be changed while no tick is in flight. There is no
// clearing pass after reset; the block is ready on the first cycle out of
// reset.
//
// ----------------------------------------------------------------------------
`default_nettype none

module four_voice_square_wave_synth_top (
    input  logic       clk,
    input  logic       rst_n,
    fvs_in_if.sink     in_ch,
    fvs_out_if.source  out_ch,
    fvs_cfg_if.sink    cfg
);
    import fvs_pkg::*;

    // front -> queue
    logic   q_push;
    item_t  q_item;
    logic   q_full;

    // queue -> back
    q_rd_t  q_rd;
    logic   q_pop;

    // tick intake and word classification
    fvs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    // decouples intake from execution
    fvs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd      (q_rd)
    );

    // word decode, step divider, voice sum, filter and result register
    fvs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .q_pop  (q_pop),
        .cfg    (cfg),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
